/* hdl/nsb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsb_pkg
// Shared types, constants and helpers of the notch-with-slopes biquad filter.
// ----------------------------------------------------------------------------
package nsb_pkg;

    localparam int NUM_INSTANCES = 8;
    localparam int INST_W        = 3;
    localparam int DATA_W        = 32;
    localparam int COEF_W        = 48;
    localparam int ACC_W         = 82;
    localparam int MUL_W         = 33;
    localparam int PROD_W        = 66;
    localparam int DIV_STEPS     = 31;
    localparam int CNT_W         = 5;
    localparam int ADDR_W        = 4;

    localparam logic [16:0] SAMPLE_PERIOD_RST = 17'd655;
    localparam logic [30:0] DAMPING_RST       = 31'd65536;

    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    localparam logic signed [DATA_W-1:0] OUT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] OUT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [1:0] {
        REG_SAMPLE_PERIOD = 2'd0,
        REG_DAMPING       = 2'd1,
        REG_MOVING_ENABLE = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [16:0] sample_period;
        logic [30:0] damping;
        logic        moving_enable;
    } cfg_t;

    typedef struct packed {
        logic neg;
        logic sh;
    } mul_tag_t;

    typedef struct packed {
        logic [PROD_W-1:0] prod;
        logic              neg;
        logic              sh;
    } mul_res_t;

    typedef struct packed {
        logic                 done;
        logic                 ovf;
        logic [DIV_STEPS-1:0] quo;
    } div_res_t;

    // clamp a 50-bit signed value to the 48-bit coefficient range
    function automatic logic signed [COEF_W-1:0] sat48(input logic signed [49:0] v);
        logic signed [COEF_W-1:0] r;
        if (v[49:47] != {3{v[49]}}) begin
            r = v[49] ? COEF_MIN : COEF_MAX;
        end else begin
            r = v[COEF_W-1:0];
        end
        return r;
    endfunction

endpackage

/* hdl/nsb_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsb_regs
// APB configuration registers: sample period, damping, moving enable.
// ----------------------------------------------------------------------------
module nsb_regs (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [nsb_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output nsb_pkg::cfg_t             cfg
);
    import nsb_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sample_period <= SAMPLE_PERIOD_RST;
            cfg_reg.damping       <= DAMPING_RST;
            cfg_reg.moving_enable <= 1'b0;
        end else if (wr_en) begin
            case (idx)
                REG_SAMPLE_PERIOD: cfg_reg.sample_period <= pwdata[16:0];
                REG_DAMPING:       cfg_reg.damping       <= pwdata[30:0];
                REG_MOVING_ENABLE: cfg_reg.moving_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_SAMPLE_PERIOD: prdata = {15'd0, cfg_reg.sample_period};
            REG_DAMPING:       prdata = {1'b0, cfg_reg.damping};
            REG_MOVING_ENABLE: prdata = {31'd0, cfg_reg.moving_enable};
            default:           prdata = '0;
        endcase
    end

endmodule

/* hdl/nsb_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsb_mul
// Shared 33x33 unsigned multiplier with registered product and sign/shift tag.
// ----------------------------------------------------------------------------
module nsb_mul (
    input  logic                      aclk,
    input  logic [nsb_pkg::MUL_W-1:0] op_a,
    input  logic [nsb_pkg::MUL_W-1:0] op_b,
    input  nsb_pkg::mul_tag_t         tag,
    output nsb_pkg::mul_res_t         res
);
    import nsb_pkg::*;

    mul_res_t res_reg;

    assign res = res_reg;

    always_ff @(posedge aclk) begin
        res_reg.prod <= PROD_W'(op_a) * PROD_W'(op_b);
        res_reg.neg  <= tag.neg;
        res_reg.sh   <= tag.sh;
    end

endmodule

/* hdl/nsb_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsb_div
// Restoring divider, one quotient bit per cycle, with overflow detect.
// ----------------------------------------------------------------------------
module nsb_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [nsb_pkg::ACC_W-1:0]  num,
    input  logic [nsb_pkg::COEF_W-1:0] den,
    output nsb_pkg::div_res_t          res
);
    import nsb_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic                 ovf_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [COEF_W-1:0]    rem_reg;
    logic [DIV_STEPS-1:0] low_reg;
    logic [DIV_STEPS-1:0] quo_reg;
    logic [COEF_W:0]      rem_try;
    logic                 fits;

    assign rem_try = {rem_reg, low_reg[DIV_STEPS-1]};
    assign fits    = rem_try >= {1'b0, den};
    assign res     = '{done: done_reg, ovf: ovf_reg, quo: quo_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                // quotient of 2^31 or more saturates either way
                if (num[ACC_W-1:DIV_STEPS] >= {{(ACC_W-DIV_STEPS-COEF_W){1'b0}}, den}) begin
                    ovf_reg  <= 1'b1;
                    done_reg <= 1'b1;
                end else begin
                    ovf_reg  <= 1'b0;
                    busy_reg <= 1'b1;
                    cnt_reg  <= CNT_W'(DIV_STEPS);
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num[DIV_STEPS+COEF_W-1:DIV_STEPS];
            low_reg <= num[DIV_STEPS-1:0];
        end else if (busy_reg) begin
            rem_reg <= fits ? COEF_W'(rem_try - {1'b0, den}) : rem_try[COEF_W-1:0];
            low_reg <= {low_reg[DIV_STEPS-2:0], 1'b0};
            quo_reg <= {quo_reg[DIV_STEPS-2:0], fits};
        end
    end

endmodule

/* hdl/notch_slope_biquad_filter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// notch_slope_biquad_filter_top
// Multi-instance notch-with-slopes biquad on a shared multiplier and divider.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  --------+-----------+------------------------------------------------------
//  s_      | in        | s_valid/s_ready, sample, corner_freq, instance, flags
//  m_      | out       | m_valid/m_ready, m_filtered
//  apb     | in        | psel/penable/pwrite/paddr/pwdata, prdata, pready
//
//  An item runs load, the multiplier passes, the bit-serial divider,
//  write-back and output; the coefficients are rebuilt by extra multiplier
//  passes or else reused. The divider is skipped on a zero or negative
//  divisor and stops early on a saturating quotient.
//  Reset is synchronous, active low; filter history is undefined until an
//  instance is restarted. s_ready is high only while the sequencer is idle;
//  a stalled result holds in the output register while m_ready is low.
// ----------------------------------------------------------------------------
module notch_slope_biquad_filter_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [31:0]              s_sample,
    input  logic signed [31:0]              s_corner_freq,
    input  logic [2:0]                      s_instance_req,
    input  logic                            s_restart,
    input  logic                            s_use_initial,
    input  logic signed [31:0]              s_initial_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [31:0]              m_filtered,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [nsb_pkg::ADDR_W-1:0]      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import nsb_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_MP, S_MP2, S_MQL, S_MQH, S_Q, S_COEF,
        S_N1, S_N2, S_N3, S_N4, S_N5, S_N6, S_DIVS, S_DIVW, S_WB, S_OUT
    } state_t;

    cfg_t      cfg;
    mul_res_t  mres;
    mul_tag_t  mtag;
    div_res_t  dres;
    logic [MUL_W-1:0] op_a;
    logic [MUL_W-1:0] op_b;

    state_t state_reg;
    logic [INST_W-1:0]        k_reg;
    logic signed [DATA_W-1:0] x_reg, init_reg, y_reg;
    logic signed [DATA_W-1:0] x1_reg, y1_reg, y2_reg;
    logic [30:0]              wc_reg;
    logic                     rst_reg;
    logic [31:0]              p_reg;
    logic [15:0]              p2hi_reg;
    logic [62:0]              ql_reg;
    logic [COEF_W-1:0]        q_reg;
    logic signed [COEF_W-1:0] b_reg, a2_reg, a1_reg, a0_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     m_valid_reg;
    logic signed [DATA_W-1:0] m_filtered_reg;

    logic signed [DATA_W-1:0] x_mem  [NUM_INSTANCES];
    logic signed [DATA_W-1:0] y1_mem [NUM_INSTANCES];
    logic signed [DATA_W-1:0] y2_mem [NUM_INSTANCES];
    logic signed [COEF_W-1:0] b_mem  [NUM_INSTANCES];
    logic signed [COEF_W-1:0] a2_mem [NUM_INSTANCES];
    logic signed [COEF_W-1:0] a1_mem [NUM_INSTANCES];
    logic signed [COEF_W-1:0] a0_mem [NUM_INSTANCES];

    logic signed [DATA_W:0]   dx;
    logic [DATA_W:0]          dx_mag;
    logic [COEF_W-1:0]        a1_mag, a0_mag;
    logic [DATA_W-1:0]        y1_mag, y2_mag;
    logic [ACC_W-1:0]         term_ext, term;
    logic [ACC_W-1:0]         acc_mag;
    logic [78:0]              q_full;
    logic [32:0]              t_val, d4_val;
    logic [33:0]              d8_val;
    logic                     in_range;
    logic                     div_start;
    logic signed [DATA_W-1:0] quo_s;

    nsb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nsb_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .tag  (mtag),
        .res  (mres)
    );

    nsb_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (acc_mag),
        .den     (a2_reg),
        .res     (dres)
    );

    assign s_ready    = (state_reg == S_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_filtered = m_filtered_reg;
    assign in_range   = ({1'b0, s_instance_req} < (INST_W+1)'(NUM_INSTANCES));

    assign dx     = {x_reg[DATA_W-1], x_reg} - {x1_reg[DATA_W-1], x1_reg};
    assign dx_mag = dx[DATA_W] ? (DATA_W+1)'(-dx) : dx;
    assign a1_mag = a1_reg[COEF_W-1] ? COEF_W'(-a1_reg) : a1_reg;
    assign a0_mag = a0_reg[COEF_W-1] ? COEF_W'(-a0_reg) : a0_reg;
    assign y1_mag = y1_reg[DATA_W-1] ? DATA_W'(-y1_reg) : y1_reg;
    assign y2_mag = y2_reg[DATA_W-1] ? DATA_W'(-y2_reg) : y2_reg;

    // high halves of the split products land 32 bits up
    assign term_ext = mres.sh ? {2'b0, mres.prod[47:0], 32'b0}
                              : {{(ACC_W-PROD_W){1'b0}}, mres.prod};
    assign term     = mres.neg ? ACC_W'(-term_ext) : term_ext;
    assign acc_mag  = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : acc_reg;

    assign q_full = {16'b0, ql_reg} + {mres.prod[46:0], 32'b0};
    assign t_val  = {p_reg, 1'b0};
    assign d4_val = {cfg.damping, 2'b0};
    assign d8_val = {cfg.damping, 3'b0};

    assign div_start = (state_reg == S_DIVS) && !a2_reg[COEF_W-1] && (a2_reg != '0);
    assign quo_s     = {1'b0, dres.quo};

    always_comb begin
        op_a = '0;
        op_b = '0;
        mtag = '{neg: 1'b0, sh: 1'b0};
        case (state_reg)
            S_MP: begin
                op_a = {16'b0, cfg.sample_period};
                op_b = {2'b0, wc_reg};
            end
            S_MP2: begin
                op_a = {1'b0, mres.prod[47:16]};
                op_b = {1'b0, mres.prod[47:16]};
            end
            S_MQL: begin
                op_a = {2'b0, cfg.damping};
                op_b = {1'b0, mres.prod[47:16]};
            end
            S_MQH: begin
                op_a = {2'b0, cfg.damping};
                op_b = {17'b0, p2hi_reg};
            end
            S_N1: begin
                op_a = b_reg[MUL_W-1:0];
                op_b = dx_mag;
                mtag = '{neg: dx[DATA_W], sh: 1'b0};
            end
            S_N2: begin
                op_a = {1'b0, a1_mag[31:0]};
                op_b = {1'b0, y1_mag};
                mtag = '{neg: ~(a1_reg[COEF_W-1] ^ y1_reg[DATA_W-1]), sh: 1'b0};
            end
            S_N3: begin
                op_a = {17'b0, a1_mag[47:32]};
                op_b = {1'b0, y1_mag};
                mtag = '{neg: ~(a1_reg[COEF_W-1] ^ y1_reg[DATA_W-1]), sh: 1'b1};
            end
            S_N4: begin
                op_a = {1'b0, a0_mag[31:0]};
                op_b = {1'b0, y2_mag};
                mtag = '{neg: ~(a0_reg[COEF_W-1] ^ y2_reg[DATA_W-1]), sh: 1'b0};
            end
            S_N5: begin
                op_a = {17'b0, a0_mag[47:32]};
                op_b = {1'b0, y2_mag};
                mtag = '{neg: ~(a0_reg[COEF_W-1] ^ y2_reg[DATA_W-1]), sh: 1'b1};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        k_reg    <= s_instance_req;
                        x_reg    <= s_sample;
                        wc_reg   <= s_corner_freq[31] ? 31'd0 : s_corner_freq[30:0];
                        rst_reg  <= s_restart;
                        init_reg <= s_use_initial ? s_initial_value : s_sample;
                        y_reg    <= '0;
                        // drop items for a missing instance straight to output
                        state_reg <= in_range ? S_LOAD : S_OUT;
                    end
                end
                S_LOAD: begin
                    if (rst_reg) begin
                        x1_reg <= init_reg;
                        y1_reg <= init_reg;
                        y2_reg <= init_reg;
                    end else begin
                        x1_reg <= x_mem[k_reg];
                        y1_reg <= y1_mem[k_reg];
                        y2_reg <= y2_mem[k_reg];
                    end
                    b_reg  <= b_mem[k_reg];
                    a2_reg <= a2_mem[k_reg];
                    a1_reg <= a1_mem[k_reg];
                    a0_reg <= a0_mem[k_reg];
                    state_reg <= (rst_reg || cfg.moving_enable) ? S_MP : S_N1;
                end
                S_MP:  state_reg <= S_MP2;
                S_MP2: begin
                    p_reg     <= mres.prod[47:16];
                    state_reg <= S_MQL;
                end
                S_MQL: begin
                    p2hi_reg  <= mres.prod[63:48];
                    state_reg <= S_MQH;
                end
                S_MQH: begin
                    ql_reg    <= mres.prod[62:0];
                    state_reg <= S_Q;
                end
                S_Q: begin
                    q_reg     <= (q_full[78:63] != '0) ? COEF_MAX : q_full[63:16];
                    state_reg <= S_COEF;
                end
                S_COEF: begin
                    b_reg  <= {15'b0, t_val};
                    a2_reg <= sat48($signed({2'b0, q_reg} + {17'b0, t_val} + {17'b0, d4_val}));
                    a1_reg <= sat48($signed({1'b0, q_reg, 1'b0} - {16'b0, d8_val}));
                    a0_reg <= sat48($signed({2'b0, q_reg} - {17'b0, t_val} + {17'b0, d4_val}));
                    state_reg <= S_N1;
                end
                S_N1: begin
                    acc_reg   <= '0;
                    state_reg <= S_N2;
                end
                S_N2: begin
                    acc_reg   <= acc_reg + term;
                    state_reg <= S_N3;
                end
                S_N3: begin
                    acc_reg   <= acc_reg + term;
                    state_reg <= S_N4;
                end
                S_N4: begin
                    acc_reg   <= acc_reg + term;
                    state_reg <= S_N5;
                end
                S_N5: begin
                    acc_reg   <= acc_reg + term;
                    state_reg <= S_N6;
                end
                S_N6: begin
                    acc_reg   <= acc_reg + term;
                    state_reg <= S_DIVS;
                end
                S_DIVS: begin
                    if (div_start) begin
                        state_reg <= S_DIVW;
                    end else begin
                        y_reg     <= '0;
                        state_reg <= S_WB;
                    end
                end
                S_DIVW: begin
                    if (dres.done) begin
                        if (dres.ovf) begin
                            y_reg <= acc_reg[ACC_W-1] ? OUT_MIN : OUT_MAX;
                        end else begin
                            y_reg <= acc_reg[ACC_W-1] ? DATA_W'(-quo_s) : quo_s;
                        end
                        state_reg <= S_WB;
                    end
                end
                S_WB: state_reg <= S_OUT;
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg    <= 1'b1;
                        m_filtered_reg <= y_reg;
                        state_reg      <= S_IDLE;
                    end else begin
                        m_valid_reg    <= 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_WB) begin
            x_mem[k_reg]  <= x_reg;
            y1_mem[k_reg] <= y_reg;
            y2_mem[k_reg] <= y1_reg;
            b_mem[k_reg]  <= b_reg;
            a2_mem[k_reg] <= a2_reg;
            a1_mem[k_reg] <= a1_reg;
            a0_mem[k_reg] <= a0_reg;
        end
    end

endmodule

/* hdl/nsb_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsb_chk
// Port-level checks of the notch-with-slopes biquad filter.
// ----------------------------------------------------------------------------
module nsb_chk (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic signed [31:0]         m_filtered,
    input logic                       psel,
    input logic                       pwrite,
    input logic [nsb_pkg::ADDR_W-1:0] paddr,
    input logic [31:0]                prdata,
    input logic                       pready
);
    import nsb_pkg::*;

    // an accepted item keeps the sequencer busy and s_ready low
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready ##1 !s_ready)
        else $error("s_ready returned too early after an item");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_filtered)))
        else $error("result changed while stalled");

    a_pready_high: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready dropped");

    a_enable_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && !pwrite && (paddr[3:2] == REG_MOVING_ENABLE)) |-> (prdata[31:1] == '0))
        else $error("moving enable readback has stray bits");

endmodule

bind notch_slope_biquad_filter_top nsb_chk u_nsb_chk (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_filtered (m_filtered),
    .psel       (psel),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .prdata     (prdata),
    .pready     (pready)
);

/* sim/notch_slope_biquad_filter_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// notch_slope_biquad_filter_checker
// Watches the sample and result channels and the register port, predicts
// every filtered value from a private per-instance filter state, and compares.
// ----------------------------------------------------------------------------
module notch_slope_biquad_filter_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic signed [31:0]         s_sample,
    input  logic signed [31:0]         s_corner_freq,
    input  logic [2:0]                 s_instance_req,
    input  logic                       s_restart,
    input  logic                       s_use_initial,
    input  logic signed [31:0]         s_initial_value,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic signed [31:0]         m_filtered,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [nsb_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output int                         fail_count,
    output int                         pending_count
);
    import nsb_pkg::*;

    localparam logic signed [63:0] CLIP_HI = 64'sd140737488355327;
    localparam logic signed [63:0] CLIP_LO = -64'sd140737488355328;

    logic [16:0] dt;
    logic [30:0] damp;
    logic        moving;

    logic signed [63:0] x_hist [NUM_INSTANCES];
    logic signed [63:0] y_hist [NUM_INSTANCES];
    logic signed [63:0] y_hist2[NUM_INSTANCES];
    logic signed [63:0] c_b    [NUM_INSTANCES];
    logic signed [63:0] c_a2   [NUM_INSTANCES];
    logic signed [63:0] c_a1   [NUM_INSTANCES];
    logic signed [63:0] c_a0   [NUM_INSTANCES];

    logic signed [31:0] filtered_q[$];
    int                 result_no;

    assign pending_count = filtered_q.size();

    function automatic logic signed [63:0] clip48(input logic signed [63:0] v);
        if (v > CLIP_HI) return CLIP_HI;
        if (v < CLIP_LO) return CLIP_LO;
        return v;
    endfunction

    task automatic build_coefs(input int k, input logic signed [63:0] wc);
        logic [63:0]  p, p2;
        logic [127:0] prod;
        logic signed [63:0] q, t, d4;
        p = ({47'd0, dt} * wc[63:0]) >> 16;
        p2 = (p * p) >> 16;
        prod = {97'd0, damp} * {64'd0, p2};
        prod = prod >> 16;
        q = (prod > 128'(CLIP_HI)) ? CLIP_HI : signed'(prod[63:0]);
        t = 64'(2 * p);
        d4 = 64'(4 * {33'd0, damp});
        c_b[k] = t;
        c_a2[k] = clip48(q + t + d4);
        c_a1[k] = clip48(2 * q - 2 * d4);
        c_a0[k] = clip48(q - t + d4);
    endtask

    task automatic filter_step(input logic signed [31:0] x32, input logic signed [31:0] w32,
                               input int k, input logic rs, input logic ui,
                               input logic signed [31:0] iv);
        logic signed [63:0]  x, wc, y, init;
        logic signed [127:0] num, quo;
        x = x32;
        wc = (w32 < 0) ? 64'sd0 : 64'(w32);
        if (rs) begin
            init = ui ? 64'(iv) : x;
            x_hist[k] = init;
            y_hist[k] = init;
            y_hist2[k] = init;
        end
        if (rs || moving) build_coefs(k, wc);
        if (c_a2[k] <= 0) begin
            y = 0;
        end else begin
            num = 128'(c_b[k]) * 128'(x - x_hist[k]) - 128'(c_a1[k]) * 128'(y_hist[k])
                - 128'(c_a0[k]) * 128'(y_hist2[k]);
            quo = num / 128'(c_a2[k]);
            if (quo > 128'sd2147483647) y = 64'sd2147483647;
            else if (quo < -128'sd2147483648) y = -64'sd2147483648;
            else y = 64'(quo);
        end
        x_hist[k] = x;
        y_hist2[k] = y_hist[k];
        y_hist[k] = y;
        filtered_q.push_back(y[31:0]);
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at result %0d: %s", result_no, what);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        result_no = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            dt <= SAMPLE_PERIOD_RST;
            damp <= DAMPING_RST;
            moving <= 1'b0;
            filtered_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_SAMPLE_PERIOD: dt <= pwdata[16:0];
                    REG_DAMPING:       damp <= pwdata[30:0];
                    REG_MOVING_ENABLE: moving <= pwdata[0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (filtered_q.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    if (m_filtered !== filtered_q[0])
                        report_mismatch($sformatf("filtered got %0d want %0d",
                                                  m_filtered, filtered_q[0]));
                    void'(filtered_q.pop_front());
                end
                result_no++;
            end
            if (s_valid && s_ready)
                filter_step(s_sample, s_corner_freq, int'(s_instance_req), s_restart,
                            s_use_initial, s_initial_value);
        end
    end
endmodule

/* sim/notch_slope_biquad_filter_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// notch_slope_biquad_filter_top_test
// Drives directed and random samples across all filter instances and several
// register settings, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module notch_slope_biquad_filter_top_test;
    import nsb_pkg::*;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic signed [31:0]         s_sample = '0;
    logic signed [31:0]         s_corner_freq = '0;
    logic [2:0]                 s_instance_req = '0;
    logic                       s_restart = 1'b0;
    logic                       s_use_initial = 1'b0;
    logic signed [31:0]         s_initial_value = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [31:0]         m_filtered;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [ADDR_W-1:0]          paddr = '0;
    logic [31:0]                pwdata = '0;
    logic [31:0]                prdata;
    logic                       pready;
    int                         fail_count;
    int                         pending_count;
    bit                         live [NUM_INSTANCES];
    int                         burst_left = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    notch_slope_biquad_filter_top u_top (.*);

    notch_slope_biquad_filter_checker u_checker (.*);

    // receiver stall pattern: long ready stretches, short and long stalls
    always @(negedge aclk) begin
        case ($urandom_range(0, 3))
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 9) != 0);
            2:       m_ready <= ($urandom_range(0, 1) != 0);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * int'(idx));
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    task automatic send_sample(input logic signed [31:0] x, input logic signed [31:0] wc,
                               input logic [2:0] k, input logic rs, input logic ui,
                               input logic signed [31:0] iv);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_sample <= x;
        s_corner_freq <= wc;
        s_instance_req <= k;
        s_restart <= rs;
        s_use_initial <= ui;
        s_initial_value <= iv;
        live[k] = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return 32'($urandom_range(0, 65536 * 8)) - 32'sd262144;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic signed [31:0] pick_freq();
        case ($urandom_range(0, 5))
            0:       return -$signed(32'($urandom_range(1, 1000000)));
            1:       return $urandom();
            2:       return 32'sh7fffffff;
            default: return 32'($urandom_range(0, 65536 * 200));
        endcase
    endfunction

    task automatic random_phase(input int count);
        logic [2:0] k;
        logic       rs;
        for (int i = 0; i < count; i++) begin
            k = 3'($urandom_range(0, NUM_INSTANCES - 1));
            rs = !live[k] || ($urandom_range(0, 19) == 0);
            send_sample(pick_value(), pick_freq(), k, rs, 1'($urandom_range(0, 1)),
                        pick_value());
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: restart every instance, then extremes and special cases
        for (int k = 0; k < NUM_INSTANCES; k++)
            send_sample(32'sh00010000 * k, 32'sh00640000, 3'(k), 1'b1, k[0], -32'sh00020000);
        send_sample(32'sh7fffffff, 32'sh7fffffff, 3'd0, 1'b0, 1'b0, 0);
        send_sample(32'sh80000000, -32'sd1, 3'd1, 1'b1, 1'b1, 32'sh7fffffff);
        send_sample(32'sh7fffffff, 32'sh80000000, 3'd1, 1'b0, 1'b0, 0);
        send_sample(32'sh80000000, 32'sd0, 3'd2, 1'b1, 1'b0, 32'sh80000000);
        send_sample(32'sh7fffffff, 32'sh00010000, 3'd2, 1'b0, 1'b1, 32'sh7fffffff);
        send_sample(32'sh00000000, 32'sh00c80000, 3'd7, 1'b0, 1'b0, 0);

        // zero damping with zero sample period gives a zero divisor
        wait_drained();
        write_reg(REG_DAMPING, 32'd0);
        write_reg(REG_SAMPLE_PERIOD, 32'd0);
        send_sample(32'sh00050000, 32'sh00100000, 3'd3, 1'b1, 1'b0, 0);
        send_sample(32'sh00060000, 32'sh00100000, 3'd3, 1'b0, 1'b0, 0);
        random_phase(250);

        // pause until drained, then settings sweep
        wait_drained();
        write_reg(REG_SAMPLE_PERIOD, 32'd65536);
        write_reg(REG_DAMPING, 32'h7fffffff);
        write_reg(REG_MOVING_ENABLE, 32'd1);
        random_phase(300);
        wait_drained();
        write_reg(REG_SAMPLE_PERIOD, 32'd1);
        write_reg(REG_DAMPING, 32'd1);
        random_phase(250);
        wait_drained();
        write_reg(REG_SAMPLE_PERIOD, 32'd655);
        write_reg(REG_DAMPING, 32'd45875);
        write_reg(REG_MOVING_ENABLE, 32'd0);
        random_phase(350);
        wait_drained();
        write_reg(REG_SAMPLE_PERIOD, 32'($urandom_range(1, 65536)));
        write_reg(REG_DAMPING, $urandom() >> 1);
        write_reg(REG_MOVING_ENABLE, 32'd1);
        random_phase(380);

        wait_drained();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end
endmodule
